// ----- rtl/jid_pkg.sv -----
// Package with the shared types, codes and constants of the Jacobi-to-distance converter.
`default_nettype none

package jid_pkg;

  // Field widths.
  localparam int LEN_W   = 24;
  localparam int ANG_W   = 16;
  localparam int MASS_W  = 18;
  localparam int MSUM_W  = 19;
  localparam int DIST_W  = 25;
  localparam int G_W     = 13;

  // Angle format: degrees with this many fraction bits.
  localparam int ANG_FRAC = 7;

  localparam logic [ANG_W-1:0] ANG_FULL    = ANG_W'(360 << ANG_FRAC);
  localparam logic [ANG_W-1:0] ANG_QUARTER = ANG_W'(90 << ANG_FRAC);
  localparam logic [ANG_W-1:0] ANG_EIGHTH  = ANG_W'(45 << ANG_FRAC);

  // pi/180 in Q32 and one in Q30.
  localparam logic [26:0] PI_Q32  = 27'd74961321;
  localparam logic [30:0] Q30_ONE = 31'h4000_0000;

  localparam logic [MASS_W-1:0] MASS_RESET = MASS_W'(1024);
  localparam logic [DIST_W-1:0] DIST_MAX   = {DIST_W{1'b1}};

  // Series divisors and their Q32 reciprocals, floor(2^32 / d).
  localparam int SIN_N = 5;
  localparam int COS_N = 6;
  localparam logic [7:0]  SIN_DIV [SIN_N] = '{8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
  localparam logic [31:0] SIN_RCP [SIN_N] = '{32'd39045157, 32'd59652323, 32'd102261126,
                                              32'd214748364, 32'd715827882};
  localparam logic [7:0]  COS_DIV [COS_N] = '{8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2};
  localparam logic [31:0] COS_RCP [COS_N] = '{32'd32537631, 32'd47721858, 32'd76695844,
                                              32'd143165576, 32'd357913941,
                                              32'd2147483648};

  // Queue depth between front and back.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;

  // Arrangement codes.
  typedef enum logic [1:0] {
    ARR_A_BC = 2'd0,
    ARR_B_CA = 2'd1,
    ARR_C_AB = 2'd2,
    ARR_BAD  = 2'd3
  } arr_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_MASS_A = 2'd0,
    CFG_MASS_B = 2'd1,
    CFG_MASS_C = 2'd2,
    CFG_NONE   = 2'd3
  } cfg_idx_t;

  // Classified request as it travels from front to back.
  typedef struct packed {
    logic              bad;
    arr_t              arr;
    logic [LEN_W-1:0]  r;
    logic [LEN_W-1:0]  big_r;
    logic [MASS_W-1:0] m2;
    logic [MSUM_W-1:0] msum;
    logic              swap;
    logic [1:0]        k;
    logic [G_W-1:0]    g;
  } q_item_t;

  // Queue status seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

`default_nettype wire

// ----- rtl/jid_if.sv -----
// Stream interfaces for the request and result channels.
`default_nettype none

interface jid_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  arrangement;
  logic [23:0] bond_length;
  logic [23:0] atom_distance;
  logic [15:0] jacobi_angle;

  modport source (output valid, arrangement, bond_length, atom_distance, jacobi_angle,
                  input ready);
  modport sink (input valid, arrangement, bond_length, atom_distance, jacobi_angle,
                output ready);
endinterface

interface jid_out_if;
  logic        valid;
  logic        ready;
  logic [24:0] dist_ab;
  logic [24:0] dist_ac;
  logic [24:0] dist_bc;
  logic        bad_arrangement;

  modport source (output valid, dist_ab, dist_ac, dist_bc, bad_arrangement, input ready);
  modport sink (input valid, dist_ab, dist_ac, dist_bc, bad_arrangement, output ready);
endinterface

`default_nettype wire

// ----- rtl/jid_front.sv -----
// Front stage: mass registers, request acceptance, pair selection and angle folding.
`default_nettype none

module jid_front
  import jid_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_idx,
  input  wire logic [MASS_W-1:0] cfg_data,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [1:0]        in_arrangement,
  input  wire logic [LEN_W-1:0]  in_bond_length,
  input  wire logic [LEN_W-1:0]  in_atom_distance,
  input  wire logic [ANG_W-1:0]  in_jacobi_angle,
  input  wire fifo_stat_t        fstat,
  output logic                   push,
  output q_item_t                push_item
);

  logic [MASS_W-1:0] mass_a_r, mass_b_r, mass_c_r;
  logic              f_vld_r, f_vld_nxt;
  q_item_t           f_r, f_nxt;

  logic [MASS_W-1:0] m1, m2;
  logic [ANG_W-1:0]  ar, fr, kq;
  logic [1:0]        k;
  logic              take;

  // The stage can load when empty or when its content moves to the queue.
  assign in_ready  = !f_vld_r || !fstat.full;
  assign take      = in_valid && in_ready;
  assign push      = f_vld_r && !fstat.full;
  assign push_item = f_r;

  // Pick the pair masses and fold the angle into the first octant.
  always_comb begin
    unique case (arr_t'(in_arrangement))
      ARR_A_BC: begin m1 = mass_c_r; m2 = mass_b_r; end
      ARR_B_CA: begin m1 = mass_c_r; m2 = mass_a_r; end
      ARR_C_AB: begin m1 = mass_a_r; m2 = mass_b_r; end
      default:  begin m1 = mass_a_r; m2 = mass_b_r; end
    endcase

    ar = (in_jacobi_angle >= ANG_FULL) ? in_jacobi_angle - ANG_FULL : in_jacobi_angle;
    if (ar >= ANG_W'(3 * ANG_QUARTER)) begin
      k = 2'd3; kq = ANG_W'(3 * ANG_QUARTER);
    end else if (ar >= ANG_W'(2 * ANG_QUARTER)) begin
      k = 2'd2; kq = ANG_W'(2 * ANG_QUARTER);
    end else if (ar >= ANG_QUARTER) begin
      k = 2'd1; kq = ANG_QUARTER;
    end else begin
      k = 2'd0; kq = '0;
    end
    fr = ar - kq;

    f_nxt.bad   = (arr_t'(in_arrangement) == ARR_BAD);
    f_nxt.arr   = arr_t'(in_arrangement);
    f_nxt.r     = in_bond_length;
    f_nxt.big_r = in_atom_distance;
    f_nxt.m2    = m2;
    f_nxt.msum  = MSUM_W'(m1) + MSUM_W'(m2);
    f_nxt.k     = k;
    f_nxt.swap  = (fr > ANG_EIGHTH);
    f_nxt.g     = f_nxt.swap ? G_W'(ANG_QUARTER - fr) : G_W'(fr);

    if (take) begin
      f_vld_nxt = 1'b1;
    end else if (push) begin
      f_vld_nxt = 1'b0;
    end else begin
      f_vld_nxt = f_vld_r;
    end
  end

  // Configuration registers and the front register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mass_a_r <= MASS_RESET;
      mass_b_r <= MASS_RESET;
      mass_c_r <= MASS_RESET;
      f_vld_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_idx))
          CFG_MASS_A: mass_a_r <= cfg_data;
          CFG_MASS_B: mass_b_r <= cfg_data;
          CFG_MASS_C: mass_c_r <= cfg_data;
          default:    ;
        endcase
      end
      f_vld_r <= f_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      f_r <= f_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/jid_fifo.sv -----
// Short request queue between the front and the back.
`default_nettype none

module jid_fifo
  import jid_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  q_item_t   push_item,
  input  wire logic pop,
  output q_item_t   head,
  output fifo_stat_t fstat
);

  q_item_t            mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wp_r, rp_r;
  logic [FIFO_AW:0]   cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign fstat.full  = (cnt_r == (FIFO_AW+1)'(FIFO_DEPTH));
  assign fstat.empty = (cnt_r == '0);
  assign do_push     = push && !fstat.full;
  assign do_pop      = pop && !fstat.empty;
  assign head        = mem[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (do_pop) begin
        rp_r <= rp_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wp_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/jid_back.sv -----
// Back pipeline: mass split, sine and cosine series, projections and square roots.
`default_nettype none

module jid_back
  import jid_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  q_item_t          head,
  input  fifo_stat_t       fstat,
  output logic             pop,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [DIST_W-1:0] out_dist_ab,
  output logic [DIST_W-1:0] out_dist_ac,
  output logic [DIST_W-1:0] out_dist_bc,
  output logic             out_bad
);

  // Stage plan.
  localparam int S_SER   = 2;
  localparam int S_DIV0  = 2;
  localparam int S_SVAL  = S_SER + 3 * SIN_N;
  localparam int S_MERGE = S_DIV0 + LEN_W;
  localparam int S_RSC   = S_MERGE + 1;
  localparam int S_Y     = S_MERGE + 2;
  localparam int S_SQ    = S_MERGE + 3;
  localparam int S_SUM   = S_MERGE + 4;
  localparam int S_SQRT0 = S_MERGE + 5;
  localparam int RT_W    = 26;
  localparam int NST     = S_SQRT0 + RT_W;

  typedef struct packed {
    q_item_t      it;
    logic [29:0]  x;
    logic [29:0]  x2;
    logic [30:0]  st;
    logic [30:0]  ct;
    logic [29:0]  sv;
    logic [29:0]  cv;
    logic [29:0]  sqe;
    logic [29:0]  cqe;
    logic [30:0]  sval;
    logic [42:0]  dnum;
    logic [18:0]  drem;
    logic [23:0]  dlow;
    logic [23:0]  quot;
    logic [23:0]  u1;
    logic [23:0]  u2;
    logic [30:0]  sn;
    logic [30:0]  cs;
    logic [24:0]  rs;
    logic [24:0]  rc;
    logic [25:0]  y1m;
    logic [25:0]  y2m;
    logic [50:0]  a1;
    logic [50:0]  a2;
    logic [50:0]  a3;
    logic [51:0]  rad1;
    logic [51:0]  rad2;
    logic [27:0]  sr1;
    logic [27:0]  sr2;
    logic [RT_W-1:0] rt1;
    logic [RT_W-1:0] rt2;
  } pipe_t;

  pipe_t stg_in  [NST];
  pipe_t stg_nxt [NST];
  pipe_t stg_r   [NST];
  logic  vld_r   [NST];
  logic  adv;

  logic              out_vld_r;
  logic [DIST_W-1:0] ab_r, ac_r, bc_r;
  logic              bad_r;
  logic [DIST_W-1:0] ab_nxt, ac_nxt, bc_nxt, d1, d2, rr;

  // The whole pipe moves when the output register can take a result.
  assign adv       = !out_vld_r || out_ready;
  assign pop       = adv && !fstat.empty;
  assign out_valid = out_vld_r;

  // Square-root step on one lane.
  function automatic void sqrt_step(input logic [27:0] rem, input logic [RT_W-1:0] rt,
                                    input logic [51:0] rad, output logic [27:0] rem_o,
                                    output logic [RT_W-1:0] rt_o,
                                    output logic [51:0] rad_o);
    logic [29:0] rn;
    logic [29:0] tr;
    rn = {rem, rad[51:50]};
    tr = {2'b00, rt, 2'b01};
    if (rn >= tr) begin
      rem_o = 28'(rn - tr);
      rt_o  = {rt[RT_W-2:0], 1'b1};
    end else begin
      rem_o = rn[27:0];
      rt_o  = {rt[RT_W-2:0], 1'b0};
    end
    rad_o = {rad[49:0], 2'b00};
  endfunction

  // Stage logic.
  always_comb begin
    logic [42:0]  num;
    logic [19:0]  rem2;
    logic [37:0]  sprod, cprod, sdiff, cdiff;
    logic [30:0]  s_, c_;
    logic signed [26:0] srs, y1, y2;
    logic [27:0]  r1, r2;
    logic [RT_W-1:0] t1, t2;
    logic [51:0]  q1, q2;

    for (int s = 0; s < NST; s++) begin
      stg_in[s]  = (s == 0) ? pipe_t'(0) : stg_r[s-1];
      stg_nxt[s] = stg_in[s];
    end
    stg_in[0].it  = head;
    stg_nxt[0].it = head;

    // Stage 0: angle to radians and the weighted bond product.
    stg_nxt[0].x    = 30'((40'(head.g) * 40'(PI_Q32) + (40'(1) << (ANG_FRAC + 1)))
                          >> (ANG_FRAC + 2));
    stg_nxt[0].dnum = 43'(42'(head.r) * 42'(head.m2));
    stg_nxt[0].st   = Q30_ONE;
    stg_nxt[0].ct   = Q30_ONE;

    // Stage 1: rounding term of the split and the squared angle.
    num = stg_in[1].dnum + 43'(stg_in[1].it.msum >> 1);
    stg_nxt[1].dnum = num;
    stg_nxt[1].drem = num[42:24];
    stg_nxt[1].dlow = num[23:0];
    stg_nxt[1].quot = '0;
    stg_nxt[1].x2   = 30'((60'(stg_in[1].x) * 60'(stg_in[1].x)) >> 30);

    // Long division by the pair mass, one quotient bit a stage.
    for (int s = S_DIV0; s < S_DIV0 + LEN_W; s++) begin
      rem2 = {stg_in[s].drem, stg_in[s].dlow[23]};
      if (rem2 >= 20'(stg_in[s].it.msum)) begin
        stg_nxt[s].drem = 19'(rem2 - 20'(stg_in[s].it.msum));
        stg_nxt[s].quot = {stg_in[s].quot[22:0], 1'b1};
      end else begin
        stg_nxt[s].drem = rem2[18:0];
        stg_nxt[s].quot = {stg_in[s].quot[22:0], 1'b0};
      end
      stg_nxt[s].dlow = {stg_in[s].dlow[22:0], 1'b0};
    end

    // Series terms, three stages each: product, reciprocal, correction.
    for (int j = 0; j < COS_N; j++) begin
      stg_nxt[S_SER+3*j].cv = 30'((61'(stg_in[S_SER+3*j].x2) * 61'(stg_in[S_SER+3*j].ct))
                                  >> 30);
      stg_nxt[S_SER+3*j+1].cqe = 30'((62'(stg_in[S_SER+3*j+1].cv) * 62'(COS_RCP[j])) >> 32);
      cprod = 38'(stg_in[S_SER+3*j+2].cqe) * 38'(COS_DIV[j]);
      cdiff = 38'(stg_in[S_SER+3*j+2].cv) - cprod;
      stg_nxt[S_SER+3*j+2].ct = Q30_ONE - 31'(stg_in[S_SER+3*j+2].cqe)
                                - ((cdiff >= 38'(COS_DIV[j])) ? 31'd1 : 31'd0);
    end
    for (int j = 0; j < SIN_N; j++) begin
      stg_nxt[S_SER+3*j].sv = 30'((61'(stg_in[S_SER+3*j].x2) * 61'(stg_in[S_SER+3*j].st))
                                  >> 30);
      stg_nxt[S_SER+3*j+1].sqe = 30'((62'(stg_in[S_SER+3*j+1].sv) * 62'(SIN_RCP[j])) >> 32);
      sprod = 38'(stg_in[S_SER+3*j+2].sqe) * 38'(SIN_DIV[j]);
      sdiff = 38'(stg_in[S_SER+3*j+2].sv) - sprod;
      stg_nxt[S_SER+3*j+2].st = Q30_ONE - 31'(stg_in[S_SER+3*j+2].sqe)
                                - ((sdiff >= 38'(SIN_DIV[j])) ? 31'd1 : 31'd0);
    end

    // Sine from the odd series.
    stg_nxt[S_SVAL].sval = 31'((61'(stg_in[S_SVAL].x) * 61'(stg_in[S_SVAL].st)) >> 30);

    // Split of the bond and quadrant selection of sine and cosine.
    if (stg_in[S_MERGE].it.msum == '0) begin
      stg_nxt[S_MERGE].u1 = stg_in[S_MERGE].it.r >> 1;
    end else begin
      stg_nxt[S_MERGE].u1 = stg_in[S_MERGE].quot;
    end
    stg_nxt[S_MERGE].u2 = stg_in[S_MERGE].it.r - stg_nxt[S_MERGE].u1;
    s_ = stg_in[S_MERGE].it.swap ? stg_in[S_MERGE].ct : stg_in[S_MERGE].sval;
    c_ = stg_in[S_MERGE].it.swap ? stg_in[S_MERGE].sval : stg_in[S_MERGE].ct;
    stg_nxt[S_MERGE].sn = stg_in[S_MERGE].it.k[0] ? c_ : s_;
    stg_nxt[S_MERGE].cs = stg_in[S_MERGE].it.k[0] ? s_ : c_;

    // Projections of the atom distance.
    stg_nxt[S_RSC].rs = 25'((56'(stg_in[S_RSC].it.big_r) * 56'(stg_in[S_RSC].sn)
                             + (56'(1) << 29)) >> 30);
    stg_nxt[S_RSC].rc = 25'((56'(stg_in[S_RSC].it.big_r) * 56'(stg_in[S_RSC].cs)
                             + (56'(1) << 29)) >> 30);

    // Offsets along the diatom axis.
    srs = stg_in[S_Y].it.k[1] ? -$signed({2'b00, stg_in[S_Y].rs})
                              : $signed({2'b00, stg_in[S_Y].rs});
    y1  = srs - $signed({3'b000, stg_in[S_Y].u1});
    y2  = srs + $signed({3'b000, stg_in[S_Y].u2});
    stg_nxt[S_Y].y1m = y1[26] ? 26'(-y1) : 26'(y1);
    stg_nxt[S_Y].y2m = y2[26] ? 26'(-y2) : 26'(y2);

    // Squares and sums.
    stg_nxt[S_SQ].a1 = 51'(52'(stg_in[S_SQ].y1m) * 52'(stg_in[S_SQ].y1m));
    stg_nxt[S_SQ].a2 = 51'(52'(stg_in[S_SQ].y2m) * 52'(stg_in[S_SQ].y2m));
    stg_nxt[S_SQ].a3 = 51'(50'(stg_in[S_SQ].rc) * 50'(stg_in[S_SQ].rc));
    stg_nxt[S_SUM].rad1 = 52'(stg_in[S_SUM].a1) + 52'(stg_in[S_SUM].a3);
    stg_nxt[S_SUM].rad2 = 52'(stg_in[S_SUM].a2) + 52'(stg_in[S_SUM].a3);
    stg_nxt[S_SUM].sr1  = '0;
    stg_nxt[S_SUM].sr2  = '0;
    stg_nxt[S_SUM].rt1  = '0;
    stg_nxt[S_SUM].rt2  = '0;

    // Square roots, one result bit a stage on each lane.
    for (int s = S_SQRT0; s < NST; s++) begin
      sqrt_step(stg_in[s].sr1, stg_in[s].rt1, stg_in[s].rad1, r1, t1, q1);
      sqrt_step(stg_in[s].sr2, stg_in[s].rt2, stg_in[s].rad2, r2, t2, q2);
      stg_nxt[s].sr1  = r1;
      stg_nxt[s].rt1  = t1;
      stg_nxt[s].rad1 = q1;
      stg_nxt[s].sr2  = r2;
      stg_nxt[s].rt2  = t2;
      stg_nxt[s].rad2 = q2;
    end
  end

  // Saturation and placement of the three distances.
  always_comb begin
    d1 = (stg_r[NST-1].rt1 > RT_W'(DIST_MAX)) ? DIST_MAX : DIST_W'(stg_r[NST-1].rt1);
    d2 = (stg_r[NST-1].rt2 > RT_W'(DIST_MAX)) ? DIST_MAX : DIST_W'(stg_r[NST-1].rt2);
    rr = DIST_W'(stg_r[NST-1].it.r);
    unique case (stg_r[NST-1].it.arr)
      ARR_A_BC: begin ab_nxt = d2; ac_nxt = d1; bc_nxt = rr; end
      ARR_B_CA: begin ab_nxt = d2; ac_nxt = rr; bc_nxt = d1; end
      ARR_C_AB: begin ab_nxt = rr; ac_nxt = d1; bc_nxt = d2; end
      default:  begin ab_nxt = '0; ac_nxt = '0; bc_nxt = '0; end
    endcase
  end

  // Valid chain.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NST; s++) begin
        vld_r[s] <= 1'b0;
      end
      out_vld_r <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= !fstat.empty;
      for (int s = 1; s < NST; s++) begin
        vld_r[s] <= vld_r[s-1];
      end
      out_vld_r <= vld_r[NST-1];
    end
  end

  // Stage payloads and the result register.
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int s = 0; s < NST; s++) begin
        stg_r[s] <= stg_nxt[s];
      end
      ab_r  <= ab_nxt;
      ac_r  <= ac_nxt;
      bc_r  <= bc_nxt;
      bad_r <= stg_r[NST-1].it.bad;
    end
  end

  assign out_dist_ab = ab_r;
  assign out_dist_ac = ac_r;
  assign out_dist_bc = bc_r;
  assign out_bad     = bad_r;

endmodule

`default_nettype wire

// ----- rtl/jacobi_to_internuclear_distances_top.sv -----
// Top level of the triatomic Jacobi-to-internuclear-distance converter.
// The block takes one Jacobi point per clock while its front stage can load and
// returns the three internuclear distances of it in request order, through one
// front register, the four-entry queue, a 57-stage back pipeline and the result
// register. Most back stages belong to the 24-step division that splits the
// bond by the pair masses and the 26-step square roots, each one bit per stage.
// A stalled result holds the back pipeline, while the front and the queue keep
// taking requests until the queue fills. The user must write masses through the
// configuration port only while the block is idle; the block does not check it.
// An invalid arrangement code returns zero distances with the error flag set.
`default_nettype none

module jacobi_to_internuclear_distances_top
  import jid_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_idx,
  input  wire logic [MASS_W-1:0] cfg_data,
  jid_in_if.sink                 in_ch,
  jid_out_if.source              out_ch
);

  fifo_stat_t fstat;
  logic       push, pop;
  q_item_t    push_item, head;

  jid_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_idx          (cfg_idx),
    .cfg_data         (cfg_data),
    .in_valid         (in_ch.valid),
    .in_ready         (in_ch.ready),
    .in_arrangement   (in_ch.arrangement),
    .in_bond_length   (in_ch.bond_length),
    .in_atom_distance (in_ch.atom_distance),
    .in_jacobi_angle  (in_ch.jacobi_angle),
    .fstat            (fstat),
    .push             (push),
    .push_item        (push_item)
  );

  jid_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .fstat     (fstat)
  );

  jid_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head        (head),
    .fstat       (fstat),
    .pop         (pop),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_dist_ab (out_ch.dist_ab),
    .out_dist_ac (out_ch.dist_ac),
    .out_dist_bc (out_ch.dist_bc),
    .out_bad     (out_ch.bad_arrangement)
  );

endmodule

`default_nettype wire

// ----- rtl/jid_checker.sv -----
// Port-level checks of the converter and their binding to the top level.
`default_nettype none

module jid_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [24:0] dist_ab,
  input wire logic [24:0] dist_ac,
  input wire logic [24:0] dist_bc,
  input wire logic        bad
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(dist_ab) && $stable(dist_ac) && $stable(dist_bc)
                                && $stable(bad))
    else $error("result payload changed while stalled");

  // An invalid arrangement gives zero distances.
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && bad |-> dist_ab == '0 && dist_ac == '0 && dist_bc == '0)
    else $error("nonzero distance with bad arrangement");

  // Nothing is offered right after reset.
  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(!rst_n) |-> !out_valid)
    else $error("result offered right after reset");

endmodule

bind jacobi_to_internuclear_distances_top jid_checker u_jid_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .dist_ab   (out_ch.dist_ab),
  .dist_ac   (out_ch.dist_ac),
  .dist_bc   (out_ch.dist_bc),
  .bad       (out_ch.bad_arrangement)
);

`default_nettype wire
